@@ rtl/spmv_pkg.sv @@
// ----------------------------------------------------------------------------
// spmv_pkg
// Shared constants, command and register codes, and beat types for the
// CSR sparse matrix times dense vector block.
// ----------------------------------------------------------------------------
`default_nettype none

package spmv_pkg;

    localparam int VECTOR_DEPTH = 1024;
    localparam int VALUE_WIDTH  = 32;
    localparam int ADDR_W       = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;

    localparam int CMD_W      = 2;
    localparam int COL_W      = 10;
    localparam int ROW_W      = 16;
    localparam int VLEN_W     = 11;
    localparam int ACC_W      = 64;
    localparam int PROD_W     = 2 * VALUE_WIDTH;
    localparam int SUM_W      = 32;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ENTRY = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLOSE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_VECTOR_LENGTH = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT     = 8'd1;

    localparam logic [VLEN_W-1:0] VLEN_RESET = 11'd1024;

    typedef struct packed {
        logic [CMD_W-1:0]        cmd;
        logic [COL_W-1:0]        column;
        logic signed [31:0]      operand;
    } t_spmv_in;

    typedef struct packed {
        logic [ROW_W-1:0]        row_index;
        logic signed [SUM_W-1:0] row_sum;
        logic                    saturated;
        logic                    column_error;
    } t_spmv_out;

    // Item after the vector store read.
    typedef struct packed {
        logic [CMD_W-1:0]              cmd;
        logic                          col_ok;
        logic signed [VALUE_WIDTH-1:0] a;
        logic signed [VALUE_WIDTH-1:0] x;
    } t_spmv_s1;

    // Snapshot of the row state taken at a close.
    typedef struct packed {
        logic [ROW_W-1:0]        row_index;
        logic signed [ACC_W-1:0] acc;
        logic                    sat;
        logic                    col_err;
    } t_spmv_close;

endpackage

`default_nettype wire

@@ rtl/csr_sparse_matrix_vector_multiply_top.sv @@
// ----------------------------------------------------------------------------
// csr_sparse_matrix_vector_multiply_top
// Streaming CSR sparse matrix times dense vector with Q16.16 operands.
// ----------------------------------------------------------------------------
// Usage: the input channel carries command beats. A load beat writes one
// dense vector element, an entry beat multiplies a nonzero by the stored
// element at its column and adds it to the row sum, and a close beat emits
// one result beat (row index, rounded and clamped sum, flags) and starts the
// next row. Rows must be sent in CSR order, all vector loads first.
// The configuration channel is always ready; vector_length (index 0) and
// row_count (index 1) are to be written by the user only while the block
// is idle, which the block itself does not enforce. Throughput is one beat
// per cycle for every command mix while the receiver keeps taking results.
// The rate is set by the 64-bit saturating accumulate; the multiply has its
// own register stage ahead of it. A close beat passes the store read,
// product, row snapshot and rounding registers before its result shows.
// When the receiver stalls, the stage registers fill up and the input stops
// taking beats once they are full; nothing is dropped.
// Reset clears the row sum, the flags, the row index and all stage valid
// bits, and restores vector_length to 1024 and row_count to 0. The vector
// store is not cleared: elements must be loaded before they are used.
// ----------------------------------------------------------------------------
`default_nettype none

module csr_sparse_matrix_vector_multiply_top import spmv_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_spmv_in              i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_spmv_out                  o_out_data,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [VLEN_W-1:0] r_vector_length;
    logic [ROW_W-1:0]  r_row_count;

    logic              w_s1_valid;
    logic              w_s1_ready;
    t_spmv_s1          w_s1;
    logic              w_cl_valid;
    logic              w_cl_ready;
    t_spmv_close       w_cl;

    // Register writes never wait; an unknown index is dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vector_length <= VLEN_RESET;
            r_row_count     <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_VECTOR_LENGTH: r_vector_length <= i_cfg_data[VLEN_W-1:0];
                CFG_ROW_COUNT:     r_row_count     <= i_cfg_data[ROW_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Column check and vector store read.
    spmv_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_in_data       (i_in_data),
        .i_vector_length (r_vector_length),
        .o_s1_valid      (w_s1_valid),
        .i_s1_ready      (w_s1_ready),
        .o_s1            (w_s1)
    );

    // Multiply, accumulate and row bookkeeping.
    spmv_mac u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s1_valid  (w_s1_valid),
        .o_s1_ready  (w_s1_ready),
        .i_s1        (w_s1),
        .i_row_count (r_row_count),
        .o_cl_valid  (w_cl_valid),
        .i_cl_ready  (w_cl_ready),
        .o_cl        (w_cl)
    );

    // Rounding, clamping and the result register.
    spmv_round u_round (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cl_valid  (w_cl_valid),
        .o_cl_ready  (w_cl_ready),
        .i_cl        (w_cl),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

@@ rtl/spmv_front.sv @@
// ----------------------------------------------------------------------------
// spmv_front
// Input stage: range check of the column, dense vector store write on a
// load and registered store read for every beat.
// ----------------------------------------------------------------------------
`default_nettype none

module spmv_front import spmv_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire t_spmv_in          i_in_data,
    input  wire logic [VLEN_W-1:0] i_vector_length,
    output logic                   o_s1_valid,
    input  wire logic              i_s1_ready,
    output t_spmv_s1               o_s1
);

    logic [VALUE_WIDTH-1:0] r_mem [VECTOR_DEPTH];
    logic                   r_s1_valid;
    t_spmv_s1               r_s1;

    logic                   w_accept;
    logic                   w_col_ok;
    logic [ADDR_W-1:0]      w_addr;

    assign o_in_ready = !r_s1_valid || i_s1_ready;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_col_ok   = ({1'b0, i_in_data.column} < i_vector_length) &&
                        ({22'd0, i_in_data.column} < 32'(VECTOR_DEPTH));
    assign w_addr     = ADDR_W'(i_in_data.column);

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            if ((i_in_data.cmd == CMD_LOAD) && w_col_ok) begin
                r_mem[w_addr] <= i_in_data.operand[VALUE_WIDTH-1:0];
            end
            r_s1.x      <= r_mem[w_addr];
            r_s1.cmd    <= i_in_data.cmd;
            r_s1.col_ok <= w_col_ok;
            r_s1.a      <= i_in_data.operand[VALUE_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    assign o_s1_valid = r_s1_valid;
    assign o_s1       = r_s1;

endmodule

`default_nettype wire

@@ rtl/spmv_mac.sv @@
// ----------------------------------------------------------------------------
// spmv_mac
// Product register, saturating row accumulator, row flags and row counter.
// A close hands a snapshot of the row state downstream and clears it.
// ----------------------------------------------------------------------------
`default_nettype none

module spmv_mac import spmv_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_s1_valid,
    output logic                  o_s1_ready,
    input  wire t_spmv_s1         i_s1,
    input  wire logic [ROW_W-1:0] i_row_count,
    output logic                  o_cl_valid,
    input  wire logic             i_cl_ready,
    output t_spmv_close           o_cl
);

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    logic                     r_s2_valid;
    logic [CMD_W-1:0]         r_s2_cmd;
    logic                     r_s2_ok;
    logic signed [PROD_W-1:0] r_s2_prod;

    logic signed [ACC_W-1:0]  r_acc, n_acc;
    logic                     r_sat, n_sat;
    logic                     r_err, n_err;
    logic [ROW_W-1:0]         r_row, n_row;

    logic                     w_s2_fire;
    logic signed [ACC_W-1:0]  w_prod;
    logic signed [ACC_W-1:0]  w_sum;
    logic                     w_ovf;
    logic [ROW_W:0]           w_row_inc;
    logic                     w_row_wrap;
    logic [ROW_W-1:0]         w_row_next;

    assign w_s2_fire  = r_s2_valid && ((r_s2_cmd != CMD_CLOSE) || i_cl_ready);
    assign o_s1_ready = !r_s2_valid || w_s2_fire;

    always_ff @(posedge i_clk) begin
        if (o_s1_ready && i_s1_valid) begin
            r_s2_cmd  <= i_s1.cmd;
            r_s2_ok   <= i_s1.col_ok;
            r_s2_prod <= i_s1.a * i_s1.x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (o_s1_ready) begin
            r_s2_valid <= i_s1_valid;
        end
    end

    assign w_prod = ACC_W'(r_s2_prod);
    assign w_sum  = r_acc + w_prod;
    assign w_ovf  = (r_acc[ACC_W-1] == w_prod[ACC_W-1]) &&
                    (w_sum[ACC_W-1] != r_acc[ACC_W-1]);

    assign w_row_inc  = {1'b0, r_row} + {{ROW_W{1'b0}}, 1'b1};
    assign w_row_wrap = (i_row_count != '0) && (w_row_inc >= {1'b0, i_row_count});
    assign w_row_next = w_row_wrap ? '0 : w_row_inc[ROW_W-1:0];

    always_comb begin
        n_acc = r_acc;
        n_sat = r_sat;
        n_err = r_err;
        n_row = r_row;
        if (w_s2_fire) begin
            case (r_s2_cmd)
                CMD_ENTRY: begin
                    if (!r_s2_ok) begin
                        n_err = 1'b1;
                    end else if (w_ovf) begin
                        // Clamp at the bound on the side of the operands.
                        n_acc = r_acc[ACC_W-1] ? ACC_MIN : ACC_MAX;
                        n_sat = 1'b1;
                    end else begin
                        n_acc = w_sum;
                    end
                end
                CMD_CLOSE: begin
                    n_acc = '0;
                    n_sat = 1'b0;
                    n_err = 1'b0;
                    n_row = w_row_next;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_sat <= 1'b0;
            r_err <= 1'b0;
            r_row <= '0;
        end else begin
            r_acc <= n_acc;
            r_sat <= n_sat;
            r_err <= n_err;
            r_row <= n_row;
        end
    end

    assign o_cl_valid     = r_s2_valid && (r_s2_cmd == CMD_CLOSE);
    assign o_cl.row_index = r_row;
    assign o_cl.acc       = r_acc;
    assign o_cl.sat       = r_sat;
    assign o_cl.col_err   = r_err;

endmodule

`default_nettype wire

@@ rtl/spmv_round.sv @@
// ----------------------------------------------------------------------------
// spmv_round
// Takes a row snapshot, rounds the Q32.32 sum to Q16.16 half up, clamps it
// to the value range and holds the result beat for the receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module spmv_round import spmv_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cl_valid,
    output logic             o_cl_ready,
    input  wire t_spmv_close i_cl,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_spmv_out        o_out_data
);

    localparam int Q_W = ACC_W - 15;
    localparam logic signed [Q_W-1:0] Q_HI =
        Q_W'((64'sd1 <<< (VALUE_WIDTH - 1)) - 64'sd1);
    localparam logic signed [Q_W-1:0] Q_LO = -Q_HI - 1;

    logic                  r_s3_valid;
    t_spmv_close           r_s3;
    logic                  r_out_valid;
    t_spmv_out             r_out;

    logic                  w_s3_fire;
    logic signed [Q_W-1:0] w_q;
    logic signed [Q_W-1:0] w_clamped;
    logic                  w_sat;

    assign w_s3_fire  = r_s3_valid && (!r_out_valid || i_out_ready);
    assign o_cl_ready = !r_s3_valid || w_s3_fire;

    always_ff @(posedge i_clk) begin
        if (o_cl_ready && i_cl_valid) begin
            r_s3 <= i_cl;
        end
    end

    // Arithmetic shift by 16, plus the first dropped bit.
    assign w_q = $signed({r_s3.acc[ACC_W-1], r_s3.acc[ACC_W-1:16]}) +
                 $signed({{(Q_W-1){1'b0}}, r_s3.acc[15]});

    always_comb begin
        w_clamped = w_q;
        w_sat     = r_s3.sat;
        if (w_q > Q_HI) begin
            w_clamped = Q_HI;
            w_sat     = 1'b1;
        end else if (w_q < Q_LO) begin
            w_clamped = Q_LO;
            w_sat     = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s3_fire) begin
            r_out.row_index    <= r_s3.row_index;
            r_out.row_sum      <= SUM_W'(w_clamped);
            r_out.saturated    <= w_sat;
            r_out.column_error <= r_s3.col_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cl_ready) begin
                r_s3_valid <= i_cl_valid;
            end
            if (w_s3_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

@@ rtl/spmv_checker.sv @@
// ----------------------------------------------------------------------------
// spmv_checker
// Port-level checks of the result channel and of the reset behavior.
// ----------------------------------------------------------------------------
`default_nettype none

module spmv_checker import spmv_pkg::*; (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      o_in_ready,
    input wire logic      o_out_valid,
    input wire logic      i_out_ready,
    input wire t_spmv_out o_out_data
);

    // A stalled result beat stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result beat dropped while stalled");

    // A stalled result beat keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("result payload changed while stalled");

    // Reset empties the pipeline: no result right after it.
    a_rst_no_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat present after reset");

    // Reset empties the pipeline: the input is free right after it.
    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_ready)
        else $error("input not ready after reset");

endmodule

bind csr_sparse_matrix_vector_multiply_top spmv_checker u_spmv_checker (.*);

`default_nettype wire

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the CSR sparse matrix times dense vector block.
// A local model of the row sum, the flags and the row counter predicts one
// result beat per close; a checker compares every result beat field by field.
// Directed rows cover rounding, saturation and column limits, one test walks
// the row index round a short row count back to zero, and random CSR traffic
// runs under several idle and stall mixes.
// ----------------------------------------------------------------------------

module tb;
    import spmv_pkg::*;

    // Command code that the block does not use; such beats are dropped.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // A register index past the two real registers; writes to it are ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_NO_REGISTER = 8'hFF;

    // Cycles to let in-flight load and entry beats leave the store read and
    // product registers before a register write, with margin to spare.
    localparam int SETTLE_CYCLES = 8;

    // Cycles without any accepted beat on any channel before the run is ended.
    localparam int WATCHDOG_LIMIT = 1000;

    localparam longint ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint ACC_MIN = -64'sh7FFF_FFFF_FFFF_FFFF - 64'sd1;
    localparam longint SUM_HI  = 64'sd2147483647;
    localparam longint SUM_LO  = -64'sd2147483648;

    // Clock, reset and block ports.
    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    t_spmv_in              i_in_data   = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_spmv_out             o_out_data;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    // Idle mix of the current phase, in percent of cycles.
    int gap_pct   = 0;
    int stall_pct = 0;

    int mismatch_count = 0;
    int idle_cycles    = 0;

    // Local copy of the block state, updated at every accepted beat.
    logic signed [31:0] vec_copy [VECTOR_DEPTH];
    bit                 vec_loaded [VECTOR_DEPTH];
    int                 loaded_cols [$];
    longint             row_acc   = 0;
    logic [ROW_W-1:0]   row_ptr   = '0;
    bit                 acc_sat   = 1'b0;
    bit                 col_err   = 1'b0;
    logic [VLEN_W-1:0]  vlen_reg  = VLEN_RESET;
    logic [ROW_W-1:0]   rows_reg  = '0;

    // Row results that are due and not yet seen, oldest first.
    t_spmv_out expected_rows [$];

    csr_sparse_matrix_vector_multiply_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Model of the block
    // ------------------------------------------------------------------------

    // Number of columns that loads and entries may address: the register is
    // eleven bits wide but the store only holds VECTOR_DEPTH elements.
    function automatic int usable_columns();
        return (int'(vlen_reg) < VECTOR_DEPTH) ? int'(vlen_reg) : VECTOR_DEPTH;
    endfunction

    // Applies one accepted command beat to the local state. A close produces
    // the row result, which is queued for the checker.
    task automatic predict_row_sum(input t_spmv_in beat);
        longint    prod;
        longint    sum;
        longint    q;
        int        col;
        int        next_row;
        t_spmv_out res;
        col = int'(beat.column);
        case (beat.cmd)
            CMD_LOAD: begin
                if (col < usable_columns()) begin
                    vec_copy[col] = beat.operand;
                    if (!vec_loaded[col]) begin
                        vec_loaded[col] = 1'b1;
                        loaded_cols = {loaded_cols, col};
                    end
                end
            end
            CMD_ENTRY: begin
                if (col < usable_columns()) begin
                    prod = longint'(beat.operand) * longint'(vec_copy[col]);
                    sum  = row_acc + prod;
                    // Two addends of one sign giving a sum of the other sign
                    // means the 64-bit accumulator overflowed.
                    if (row_acc[63] == prod[63] && sum[63] != row_acc[63]) begin
                        row_acc = row_acc[63] ? ACC_MIN : ACC_MAX;
                        acc_sat = 1'b1;
                    end else begin
                        row_acc = sum;
                    end
                end else begin
                    col_err = 1'b1;
                end
            end
            CMD_CLOSE: begin
                // Q32.32 to Q16.16, ties go toward plus infinity.
                q = (row_acc >>> 16) + longint'({63'd0, row_acc[15]});
                res.saturated = acc_sat;
                if (q > SUM_HI) begin
                    q = SUM_HI;
                    res.saturated = 1'b1;
                end
                if (q < SUM_LO) begin
                    q = SUM_LO;
                    res.saturated = 1'b1;
                end
                res.row_index    = row_ptr;
                res.row_sum      = q[31:0];
                res.column_error = col_err;
                expected_rows = {expected_rows, res};
                row_acc  = 0;
                acc_sat  = 1'b0;
                col_err  = 1'b0;
                next_row = int'(row_ptr) + 1;
                if (rows_reg != '0 && next_row >= int'(rows_reg)) begin
                    row_ptr = '0;
                end else begin
                    row_ptr = next_row[ROW_W-1:0];
                end
            end
            default: begin
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------------

    // Offers one beat on the input channel, after a random idle gap, and
    // returns at the edge where it is taken.
    task automatic send_beat(input t_spmv_in beat);
        while ($urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= beat;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_row_sum(beat);
    endtask

    function automatic t_spmv_in make_beat(input logic [CMD_W-1:0] cmd, input int col,
                                           input logic signed [31:0] op);
        t_spmv_in beat;
        beat.cmd     = cmd;
        beat.column  = col[COL_W-1:0];
        beat.operand = op;
        return beat;
    endfunction

    // Stops offering beats and waits until every due row result has come and
    // the pipeline has had time to empty of beats that give no result.
    task automatic drain_pipeline();
        i_in_valid <= 1'b0;
        while (expected_rows.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register writes are only made while the block is idle.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        drain_pipeline();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_VECTOR_LENGTH) begin
            vlen_reg = data[VLEN_W-1:0];
        end else if (idx == CFG_ROW_COUNT) begin
            rows_reg = data[ROW_W-1:0];
        end
    endtask

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what, input longint want, input longint got);
        mismatch_count++;
        if (mismatch_count <= 40) begin
            $display("%0t: mismatch in %s: wanted %0d, got %0d", $realtime, what, want, got);
        end
    endtask

    // The receiver stalls at random in the share that the phase sets.
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin : check_results
        t_spmv_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_rows.size() == 0) begin
                report_mismatch("row_index of a beat with no row closed", -1,
                                longint'(o_out_data.row_index));
            end else begin
                want = expected_rows.pop_front();
                if (o_out_data.row_index !== want.row_index)
                    report_mismatch("row_index", longint'(want.row_index),
                                    longint'(o_out_data.row_index));
                if (o_out_data.row_sum !== want.row_sum)
                    report_mismatch("row_sum", longint'(want.row_sum),
                                    longint'(o_out_data.row_sum));
                if (o_out_data.saturated !== want.saturated)
                    report_mismatch("saturated", longint'(want.saturated),
                                    longint'(o_out_data.saturated));
                if (o_out_data.column_error !== want.column_error)
                    report_mismatch("column_error", longint'(want.column_error),
                                    longint'(o_out_data.column_error));
            end
        end
    end

    // Any beat on any channel restarts the count; a hung block ends the run.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Q16.16 value of random magnitude: sign-extended from a random width, so
    // that rows range from tiny sums to ones that clamp or overflow.
    function automatic logic signed [31:0] rand_operand();
        int          w;
        logic [31:0] raw;
        case ($urandom_range(5))
            0:       w = 8;
            1:       w = 12;
            2:       w = 17;
            3:       w = 20;
            4:       w = 24;
            default: w = 32;
        endcase
        raw = $urandom;
        return $signed(raw << (32 - w)) >>> (32 - w);
    endfunction

    // Picks a loaded column inside the usable length, or -1 if there is none.
    // Entries never read an element that was never loaded.
    function automatic int pick_loaded_column(input int usable);
        int legal [$];
        foreach (loaded_cols[i]) begin
            if (loaded_cols[i] < usable) legal = {legal, loaded_cols[i]};
        end
        if (legal.size() == 0) return -1;
        return legal[$urandom_range(legal.size() - 1)];
    endfunction

    // One matrix entry: mostly a legal column, sometimes one at or past the length.
    task automatic send_random_entry(input int usable);
        int col;
        col = pick_loaded_column(usable);
        if (usable < VECTOR_DEPTH && (col < 0 || $urandom_range(99) < 8)) begin
            col = $urandom_range(VECTOR_DEPTH - 1, usable);
        end
        send_beat(make_beat(CMD_ENTRY, col, rand_operand()));
    endtask

    // One configuration followed by a vector load and CSR rows, with some
    // noise beats mixed in. Only beats that the block acts on are counted.
    task automatic run_segment(input int target);
        int                counted;
        int                usable;
        int                n_loads;
        int                pick;
        logic [VLEN_W-1:0] vlen;
        logic [ROW_W-1:0]  rows;
        counted = 0;
        case ($urandom_range(10))
            0:       vlen = 11'd0;
            1:       vlen = 11'd1;
            2:       vlen = 11'd2;
            3:       vlen = 11'd5;
            4:       vlen = 11'd16;
            5:       vlen = 11'd64;
            6:       vlen = 11'd1023;
            7:       vlen = 11'd1024;
            8:       vlen = 11'd2047;
            default: vlen = VLEN_W'($urandom_range(2047));
        endcase
        case ($urandom_range(7))
            0:       rows = 16'd0;
            1:       rows = 16'd1;
            2:       rows = 16'd2;
            3:       rows = 16'd3;
            4:       rows = 16'd5;
            5:       rows = 16'd100;
            6:       rows = 16'd65535;
            default: rows = ROW_W'($urandom);
        endcase
        // Upper data bits are junk that the vector_length register drops.
        write_register(CFG_VECTOR_LENGTH, {5'($urandom), vlen});
        write_register(CFG_ROW_COUNT, rows);
        usable = usable_columns();

        // Load part of the vector, the last usable element always among it.
        if (usable > 0) begin
            n_loads = $urandom_range((usable < 24) ? usable : 24, 1);
            send_beat(make_beat(CMD_LOAD, usable - 1, rand_operand()));
            counted++;
            repeat (n_loads - 1) begin
                send_beat(make_beat(CMD_LOAD, $urandom_range(usable - 1), rand_operand()));
                counted++;
            end
        end

        while (counted < target) begin
            pick = $urandom_range(99);
            if (pick < 88) begin
                repeat ($urandom_range(6)) begin
                    send_random_entry(usable);
                    counted++;
                end
                send_beat(make_beat(CMD_CLOSE, $urandom_range(1023), $urandom));
                counted++;
            end else begin
                case (pick % 4)
                    0: send_beat(make_beat(CMD_UNUSED, $urandom_range(1023), $urandom));
                    1: begin
                        if (usable > 0) begin
                            send_beat(make_beat(CMD_LOAD, $urandom_range(usable - 1),
                                                rand_operand()));
                            counted++;
                        end
                    end
                    2: begin
                        if (usable < VECTOR_DEPTH) begin
                            send_beat(make_beat(CMD_LOAD,
                                                $urandom_range(VECTOR_DEPTH - 1, usable),
                                                $urandom));
                        end
                    end
                    default: begin
                        send_beat(make_beat(CMD_CLOSE, $urandom_range(1023), $urandom));
                        counted++;
                    end
                endcase
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Rounding ties, accumulator overflow both ways, output clamping and the
    // empty row, at the reset configuration.
    task automatic test_rounding_and_saturation();
        gap_pct   = 0;
        stall_pct = 0;
        send_beat(make_beat(CMD_LOAD, 0, 32'sh0001_0000));
        send_beat(make_beat(CMD_LOAD, 1023, 32'sh8000_0000));
        send_beat(make_beat(CMD_LOAD, 1, 32'sh7FFF_FFFF));
        send_beat(make_beat(CMD_LOAD, 2, 32'sh0000_0001));
        // An empty row sums to zero.
        send_beat(make_beat(CMD_CLOSE, 0, 32'sh0));
        // A positive half rounds up, a negative half rounds up to zero.
        send_beat(make_beat(CMD_ENTRY, 2, 32'sh0000_8000));
        send_beat(make_beat(CMD_CLOSE, 0, 32'sh0));
        send_beat(make_beat(CMD_ENTRY, 2, 32'shFFFF_8000));
        send_beat(make_beat(CMD_CLOSE, 0, 32'sh0));
        // Largest products push the accumulator past its top; the last entry
        // then works down from the saturated value.
        send_beat(make_beat(CMD_ENTRY, 1, 32'sh7FFF_FFFF));
        send_beat(make_beat(CMD_ENTRY, 1, 32'sh7FFF_FFFF));
        send_beat(make_beat(CMD_ENTRY, 1023, 32'sh8000_0000));
        send_beat(make_beat(CMD_ENTRY, 1023, 32'sh7FFF_FFFF));
        send_beat(make_beat(CMD_CLOSE, 0, 32'sh0));
        // The same past the bottom.
        repeat (3) send_beat(make_beat(CMD_ENTRY, 1023, 32'sh7FFF_FFFF));
        send_beat(make_beat(CMD_CLOSE, 0, 32'sh0));
        // Sum lands exactly on the output maximum, then the tie rounds it over:
        // the output clamps while the accumulator itself never overflowed.
        send_beat(make_beat(CMD_ENTRY, 0, 32'sh7FFF_FFFF));
        send_beat(make_beat(CMD_ENTRY, 2, 32'sh0000_8000));
        send_beat(make_beat(CMD_CLOSE, 0, 32'sh0));
        // The unused command must leave everything alone.
        send_beat(make_beat(CMD_UNUSED, 1023, 32'shFFFF_FFFF));
    endtask

    // Loads and entries beyond the vector length, register masking, an
    // unknown register index and a short row count.
    task automatic test_column_limits();
        gap_pct   = 0;
        stall_pct = 0;
        write_register(CFG_VECTOR_LENGTH, 16'hF802);
        write_register(CFG_ROW_COUNT, 16'd2);
        write_register(CFG_NO_REGISTER, 16'h0003);
        send_beat(make_beat(CMD_LOAD, 5, 32'sh1234_5678));
        send_beat(make_beat(CMD_ENTRY, 5, 32'sh0001_0000));
        send_beat(make_beat(CMD_ENTRY, 1, 32'sh0000_0010));
        repeat (3) send_beat(make_beat(CMD_CLOSE, 0, 32'sh0));
        // A zero length turns every load and entry away.
        write_register(CFG_VECTOR_LENGTH, 16'd0);
        send_beat(make_beat(CMD_ENTRY, 0, 32'sh0001_0000));
        send_beat(make_beat(CMD_LOAD, 0, 32'sh7FFF_0000));
        send_beat(make_beat(CMD_CLOSE, 0, 32'sh0));
        // A length above the store depth is limited to the store.
        write_register(CFG_VECTOR_LENGTH, 16'd2047);
        send_beat(make_beat(CMD_ENTRY, 1023, 32'sh0001_0000));
        send_beat(make_beat(CMD_CLOSE, 0, 32'sh0));
    endtask

    // With a short row_count the row index runs round and back to zero.
    task automatic test_row_wrap();
        gap_pct   = 0;
        stall_pct = 0;
        write_register(CFG_ROW_COUNT, 16'd5);
        do begin
            send_beat(make_beat(CMD_CLOSE, $urandom_range(1023), $urandom));
        end while (row_ptr != '0);
    endtask

    task automatic test_random_traffic(input int gap, input int stall);
        gap_pct   = gap;
        stall_pct = stall;
        repeat (2) run_segment(200);
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial begin
        // Synchronous reset, asserted from the start and then released.
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_rounding_and_saturation();
        test_column_limits();
        test_row_wrap();
        test_random_traffic(0, 0);
        test_random_traffic(49, 0);
        test_random_traffic(0, 49);
        test_random_traffic(14, 14);

        // Every row result must have arrived and nothing more may follow.
        drain_pipeline();
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
